>>> hdl/kaf_pkg.sv
// ----------------------------------------------------------------------------
// kaf_pkg: shared definitions of the three-axis Kalman angle filter
// Axis count, field widths, fixed-point constants, the sequencer phase code,
// the control bundle that drives the axis lanes and the register reset values.
// ----------------------------------------------------------------------------
package kaf_pkg;

  localparam int NUM_AXES  = 3;

  localparam int ANGLE_W   = 32;           // Q16.16 angles and rates
  localparam int DT_W      = 16;           // Q0.16 time step
  localparam int COV_W     = 28;           // Q4.24 P, q and r
  localparam int GAIN_W    = 25;           // Q1.24 gain, never above 1.0
  localparam int MCAND_W   = ANGLE_W + 1;  // widest signed multiplicand
  localparam int PROD_W    = MCAND_W + GAIN_W;

  localparam int MUL_STEPS = GAIN_W;       // one multiplier or quotient bit a cycle
  localparam int CNT_W     = $clog2(MUL_STEPS);

  localparam int IN_W      = 2 * NUM_AXES * ANGLE_W + DT_W;
  localparam int OUT_W     = NUM_AXES * ANGLE_W;
  localparam int CFG_AW    = $clog2(2 * NUM_AXES);

  localparam logic [GAIN_W-1:0] ONE_Q24 = GAIN_W'(1) << 24;
  localparam logic [COV_W-1:0]  P_MAX   = '1;

  typedef enum logic [1:0] {
    PH_RATE,
    PH_GAIN,
    PH_INNOV,
    PH_COV
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   load;
    logic   step;
    logic   commit;
  } ctl_t;

  function automatic logic [COV_W-1:0] meas_reset(input int axis);
    logic [2:0] sel;
    sel = 3'(axis);
    case (sel)
      3'd1:    return COV_W'(469762);
      3'd2:    return COV_W'(419430);
      default: return COV_W'(436208);
    endcase
  endfunction

  function automatic logic [COV_W-1:0] proc_reset(input int axis);
    logic [2:0] sel;
    sel = 3'(axis);
    case (sel)
      3'd2:    return COV_W'(1678);
      default: return COV_W'(83886);
    endcase
  endfunction

endpackage

>>> hdl/kaf_smul.sv
// ----------------------------------------------------------------------------
// kaf_smul: bit-serial signed by unsigned multiplier
// Shift-add multiplier that retires one multiplier bit per step, least
// significant first. The partial sum shifts right into the multiplier register.
// ----------------------------------------------------------------------------
module kaf_smul
  import kaf_pkg::*;
(
  input  logic                     clk,
  input  logic                     load,
  input  logic                     step,
  input  logic signed [MCAND_W-1:0] mcand,
  input  logic        [GAIN_W-1:0]  mplier,
  output logic signed [PROD_W-1:0]  prod
);

  logic signed [MCAND_W-1:0] mcand_r;
  logic signed [MCAND_W:0]   hi_r, hi_nxt;
  logic        [GAIN_W-1:0]  lo_r, lo_nxt;
  logic signed [MCAND_W+1:0] sum;

  always_comb begin
    sum    = (MCAND_W+2)'(hi_r) + (lo_r[0] ? (MCAND_W+2)'(mcand_r) : '0);
    hi_nxt = sum[MCAND_W+1:1];
    lo_nxt = {sum[0], lo_r[GAIN_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mcand_r <= mcand;
      hi_r    <= '0;
      lo_r    <= mplier;
    end else if (step) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign prod = {hi_r[MCAND_W-1:0], lo_r};

endmodule

>>> hdl/kaf_sdiv.sv
// ----------------------------------------------------------------------------
// kaf_sdiv: bit-serial restoring divider for the Kalman gain
// Computes floor(num * 2^24 / den) for num <= den, one quotient bit per step.
// The first step compares without a shift to produce the integer bit.
// ----------------------------------------------------------------------------
module kaf_sdiv
  import kaf_pkg::*;
(
  input  logic              clk,
  input  logic              load,
  input  logic              step,
  input  logic [COV_W-1:0]  num,
  input  logic [COV_W:0]    den,
  output logic [GAIN_W-1:0] quo
);

  logic [COV_W+1:0]  rem_r, rem_nxt;
  logic [COV_W:0]    den_r;
  logic [GAIN_W-1:0] quo_r;
  logic              first_r;
  logic [COV_W+1:0]  trial;
  logic [COV_W+2:0]  diff;
  logic              ge;

  always_comb begin
    trial   = first_r ? rem_r : {rem_r[COV_W:0], 1'b0};
    diff    = {1'b0, trial} - {2'b00, den_r};
    ge      = ~diff[COV_W+2];
    rem_nxt = ge ? diff[COV_W+1:0] : trial;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r   <= (COV_W+2)'(num);
      den_r   <= den;
      quo_r   <= '0;
      first_r <= 1'b1;
    end else if (step) begin
      rem_r   <= rem_nxt;
      quo_r   <= {quo_r[GAIN_W-2:0], ge};
      first_r <= 1'b0;
    end
  end

  assign quo = quo_r;

endmodule

>>> hdl/kaf_lane.sv
// ----------------------------------------------------------------------------
// kaf_lane: one axis of the angle filter
// Holds the angle estimate and error covariance of its axis and runs the
// predict, gain and update steps on its own serial multiplier and divider.
// ----------------------------------------------------------------------------
module kaf_lane
  import kaf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  ctl_t                      ctl,
  input  logic signed [ANGLE_W-1:0] acc,
  input  logic signed [ANGLE_W-1:0] rate,
  input  logic        [DT_W-1:0]    dt,
  input  logic        [COV_W-1:0]   meas_noise,
  input  logic        [COV_W-1:0]   proc_noise,
  output logic signed [ANGLE_W-1:0] angle
);

  logic signed [ANGLE_W-1:0] x_r, x_nxt;
  logic        [COV_W-1:0]   p_r, p_nxt;
  logic        [GAIN_W-1:0]  k_r, k_nxt;

  logic signed [MCAND_W-1:0] mcand;
  logic        [GAIN_W-1:0]  mplier;
  logic signed [PROD_W-1:0]  prod;
  logic        [GAIN_W-1:0]  quo;
  logic        [COV_W:0]     s_sum;
  logic        [COV_W:0]     p_sum;
  logic        [COV_W-1:0]   p_pred;

  logic signed [PROD_W-1:0]  rnd_rate;
  logic signed [PROD_W-1:0]  rnd_upd;
  logic signed [42:0]        x_pre;
  logic signed [42:0]        x_post;

  function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [42:0] v);
    if (v > 43'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -43'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[ANGLE_W-1:0];
    end
  endfunction

  always_comb begin
    case (ctl.phase)
      PH_RATE: begin
        mcand  = MCAND_W'(rate);
        mplier = GAIN_W'(dt);
      end
      PH_INNOV: begin
        mcand  = MCAND_W'(acc) - MCAND_W'(x_r);
        mplier = k_r;
      end
      PH_COV: begin
        mcand  = $signed(MCAND_W'(p_r));
        mplier = ONE_Q24 - k_r;
      end
      default: begin
        mcand  = '0;
        mplier = '0;
      end
    endcase
  end

  kaf_smul u_mul (
    .clk    (clk),
    .load   (ctl.load),
    .step   (ctl.step),
    .mcand  (mcand),
    .mplier (mplier),
    .prod   (prod)
  );

  assign s_sum = (COV_W+1)'(p_r) + (COV_W+1)'(meas_noise);

  kaf_sdiv u_div (
    .clk  (clk),
    .load (ctl.load),
    .step (ctl.step),
    .num  (p_r),
    .den  (s_sum),
    .quo  (quo)
  );

  always_comb begin
    // Arithmetic right shifts floor, so adding half first rounds ties upward.
    rnd_rate = prod + PROD_W'(32768);
    rnd_upd  = prod + PROD_W'(8388608);
    x_pre    = 43'(x_r) + 43'(rnd_rate >>> 16);
    x_post   = 43'(x_r) + 43'(rnd_upd >>> 24);
    p_sum    = (COV_W+1)'(p_r) + (COV_W+1)'(proc_noise);
    p_pred   = p_sum[COV_W] ? P_MAX : p_sum[COV_W-1:0];

    x_nxt = x_r;
    p_nxt = p_r;
    k_nxt = k_r;
    if (ctl.commit) begin
      case (ctl.phase)
        PH_RATE: begin
          x_nxt = sat32(x_pre);
          p_nxt = p_pred;
        end
        PH_GAIN: begin
          k_nxt = (s_sum == '0) ? '0 : quo;
        end
        PH_INNOV: begin
          x_nxt = sat32(x_post);
        end
        PH_COV: begin
          p_nxt = prod[COV_W+23:24];
        end
        default: begin
          x_nxt = x_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      p_r <= COV_W'(ONE_Q24);
    end else begin
      x_r <= x_nxt;
      p_r <= p_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
  end

  assign angle = x_r;

endmodule

>>> hdl/three_axis_kalman_angle_filter.sv
// An accepted item runs through four phases, each a load step, 25 serial steps
// of the per-axis multiplier or divider, and a commit step. in_tready is high
// only when idle, so a new item waits until the last is in the output register.
// The axes run in parallel lanes; a finished result waits in the output register
// while the next item is accepted and processed.
// Reset (synchronous, active low): estimates go to 0, covariances to 1.0, noise
// registers to their defaults, no result pending.
// ----------------------------------------------------------------------------
// three_axis_kalman_angle_filter: three-axis scalar Kalman angle filter
// Sequencer, input and output item registers and noise registers around one
// bit-serial filter lane per axis.
// ----------------------------------------------------------------------------
module three_axis_kalman_angle_filter
  import kaf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z (32 bits each), time_step (16)
  input  logic [IN_W-1:0]   in_tdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  // angle_x, angle_y, angle_z (32 bits each)
  output logic [OUT_W-1:0]  out_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [COV_W-1:0]  cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_COMMIT,
    ST_OUT
  } state_t;

  state_t           state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic [OUT_W-1:0] angles;
  logic             accept;
  logic             out_load;
  ctl_t             ctl;

  logic signed [ANGLE_W-1:0] acc_r  [NUM_AXES];
  logic signed [ANGLE_W-1:0] gyro_r [NUM_AXES];
  logic        [DT_W-1:0]    dt_r;
  logic        [COV_W-1:0]   meas_r [NUM_AXES];
  logic        [COV_W-1:0]   proc_r [NUM_AXES];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  assign ctl.phase  = phase_r;
  assign ctl.load   = (state_r == ST_LOAD);
  assign ctl.step   = (state_r == ST_RUN);
  assign ctl.commit = (state_r == ST_COMMIT);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_LOAD;
          phase_nxt = PH_RATE;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_RUN;
        cnt_nxt   = '0;
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_STEPS - 1)) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        case (phase_r)
          PH_RATE:  phase_nxt = PH_GAIN;
          PH_GAIN:  phase_nxt = PH_INNOV;
          PH_INNOV: phase_nxt = PH_COV;
          default:  phase_nxt = PH_RATE;
        endcase
        state_nxt = (phase_r == PH_COV) ? ST_OUT : ST_LOAD;
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_RATE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= angles;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        acc_r[a]  <= in_tdata[a*ANGLE_W +: ANGLE_W];
        gyro_r[a] <= in_tdata[(NUM_AXES + a)*ANGLE_W +: ANGLE_W];
      end
      dt_r <= in_tdata[2*NUM_AXES*ANGLE_W +: DT_W];
    end
  end

  // Writes to indexes beyond the register list match no entry and are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        meas_r[a] <= meas_reset(a);
        proc_r[a] <= proc_reset(a);
      end
    end else if (cfg_we) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (cfg_addr == CFG_AW'(a)) begin
          meas_r[a] <= cfg_wdata;
        end
        if (cfg_addr == CFG_AW'(NUM_AXES + a)) begin
          proc_r[a] <= cfg_wdata;
        end
      end
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    kaf_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .acc        (acc_r[a]),
      .rate       (gyro_r[a]),
      .dt         (dt_r),
      .meas_noise (meas_r[a]),
      .proc_noise (proc_r[a]),
      .angle      (angles[a*ANGLE_W +: ANGLE_W])
    );
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

endmodule
